// ===== rtl/core/tcst_pkg.sv =====
// Shared constants, types and interface structs of the touch contact slot tracker.
package tcst_pkg;

    localparam int SLOT_COUNT = 10;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int OUT_SLOT_W = 4;
    localparam int ID_BITS    = 16;
    localparam int COORD_BITS = 12;
    localparam int POS_W      = 16;
    localparam int DIM_W      = 13;
    localparam int OP_W       = 3;
    localparam int PROD_W     = POS_W + DIM_W;
    localparam int DIFF_W     = POS_W + 2;
    localparam int DIV_CNT_W  = $clog2(PROD_W);
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ROTATION     = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_PANEL_WIDTH  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_PANEL_HEIGHT = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_UI_WIDTH     = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_UI_HEIGHT    = REG_IDX_W'(4);

    localparam logic [1:0]       ROT_RESET   = 2'd0;
    localparam logic [DIM_W-1:0] PANEL_W_RST = DIM_W'(1280);
    localparam logic [DIM_W-1:0] PANEL_H_RST = DIM_W'(800);
    localparam logic [DIM_W-1:0] UI_W_RST    = DIM_W'(1280);
    localparam logic [DIM_W-1:0] UI_H_RST    = DIM_W'(800);

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    typedef enum logic [OP_W-1:0] {
        OP_FINGER_DOWN = 3'd0,
        OP_FINGER_UP   = 3'd1,
        OP_FINGER_MOVE = 3'd2,
        OP_MOUSE_DOWN  = 3'd3,
        OP_MOUSE_UP    = 3'd4,
        OP_MOUSE_MOVE  = 3'd5
    } t_op;

    typedef struct packed {
        logic [1:0]       rotation;
        logic [DIM_W-1:0] panel_width;
        logic [DIM_W-1:0] panel_height;
        logic [DIM_W-1:0] ui_width;
        logic [DIM_W-1:0] ui_height;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic look;
        logic rot;
        logic mul;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic report;
        logic div_done;
    } t_dp_status;

endpackage

// ===== rtl/core/touch_contact_slot_tracker.sv =====
// Top level of the touch contact slot tracker.
//
// The tracker takes touch and mouse pointer events one at a time and keeps a
// table of ten contact slots, each with an active mark, a finger id and a
// pressed mark. An event is taken at a rising clock edge where start is high
// and busy is low. An event that produces no report (an unknown finger on up
// or move, a mouse button other than left, mouse motion while slot 0 is not
// pressed, or an undefined operation) keeps busy high only for the lookup,
// and no new event is taken until busy falls. An event that produces a report
// keeps busy high through the slot lookup and table update, the rotation, the
// scaling multiply and the two serial dividers that divide by the panel size at
// one quotient bit per cycle. The report then appears on the result ports,
// marked by o_valid, which is high for exactly one cycle, and a new event may
// already be started in that same cycle. The receiver cannot hold a report off,
// so it must take every transfer in the cycle in which o_valid is high.
// Configuration goes through the APB-style port, one register per word at byte
// addresses 0, 4, 8, 12 and 16; it should be changed only while the tracker is
// idle, because a report in progress reads the live settings.
module touch_contact_slot_tracker import tcst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Event channel.
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [ID_BITS-1:0]    i_finger_id,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic                  i_left_button,

    // Report channel.
    output logic                  o_valid,
    output logic [OUT_SLOT_W-1:0] o_slot_index,
    output logic                  o_is_pressed,
    output logic [COORD_BITS-1:0] o_ui_x,
    output logic [COORD_BITS-1:0] o_ui_y,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg       cfg;
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       ctrl_busy;

    // Register file: rotation, panel size and UI size.
    tcst_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The controller is ready exactly when its state machine is idle; the
    // start qualification happens inside it, so a start while busy is ignored.
    tcst_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (ctrl_busy),
        .o_valid  (o_valid)
    );

    // The datapath owns the slot table and the coordinate conversion, and
    // holds the report fields stable from the strobe until the next report.
    tcst_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_operation   (i_operation),
        .i_finger_id   (i_finger_id),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_left_button (i_left_button),
        .o_slot_index  (o_slot_index),
        .o_is_pressed  (o_is_pressed),
        .o_ui_x        (o_ui_x),
        .o_ui_y        (o_ui_y)
    );

    assign busy = ctrl_busy;

endmodule

// ===== rtl/core/tcst_regs.sv =====
// Configuration register file behind the APB-style port.
module tcst_regs import tcst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation     <= ROT_RESET;
            r_cfg.panel_width  <= PANEL_W_RST;
            r_cfg.panel_height <= PANEL_H_RST;
            r_cfg.ui_width     <= UI_W_RST;
            r_cfg.ui_height    <= UI_H_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ROTATION:     r_cfg.rotation     <= pwdata[1:0];
                REG_PANEL_WIDTH:  r_cfg.panel_width  <= pwdata[DIM_W-1:0];
                REG_PANEL_HEIGHT: r_cfg.panel_height <= pwdata[DIM_W-1:0];
                REG_UI_WIDTH:     r_cfg.ui_width     <= pwdata[DIM_W-1:0];
                REG_UI_HEIGHT:    r_cfg.ui_height    <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROTATION:     prdata = APB_DATA_W'(r_cfg.rotation);
            REG_PANEL_WIDTH:  prdata = APB_DATA_W'(r_cfg.panel_width);
            REG_PANEL_HEIGHT: prdata = APB_DATA_W'(r_cfg.panel_height);
            REG_UI_WIDTH:     prdata = APB_DATA_W'(r_cfg.ui_width);
            REG_UI_HEIGHT:    prdata = APB_DATA_W'(r_cfg.ui_height);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/tcst_div.sv =====
// Restoring serial divider, one quotient bit per clock cycle.
module tcst_div import tcst_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [DIM_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quotient
);

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIM_W-1:0]     r_div;
    logic [DIM_W-1:0]     r_rem;
    logic [PROD_W-1:0]    r_quo;
    logic [DIM_W:0]       shifted;
    logic [DIM_W:0]       diff;
    logic                 fits;

    assign shifted    = {r_rem, r_quo[PROD_W-1]};
    assign diff       = shifted - {1'b0, r_div};
    assign fits       = shifted >= {1'b0, r_div};
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= DIV_CNT_W'(PROD_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_run) begin
            r_rem <= fits ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
            r_quo <= {r_quo[PROD_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/core/tcst_datapath.sv =====
// Slot table, position conversion and output registers of the tracker.
module tcst_datapath import tcst_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [OP_W-1:0]       i_operation,
    input  logic [ID_BITS-1:0]    i_finger_id,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic                  i_left_button,
    output logic [OUT_SLOT_W-1:0] o_slot_index,
    output logic                  o_is_pressed,
    output logic [COORD_BITS-1:0] o_ui_x,
    output logic [COORD_BITS-1:0] o_ui_y
);

    // Latched item.
    t_op                r_op;
    logic [ID_BITS-1:0] r_id;
    logic [POS_W-1:0]   r_px;
    logic [POS_W-1:0]   r_py;
    logic               r_left;

    // Slot table.
    logic               r_active  [SLOT_COUNT];
    logic [ID_BITS-1:0] r_cid     [SLOT_COUNT];
    logic               r_pressed [SLOT_COUNT];
    logic               r_mouse;

    // Report in flight.
    logic [SLOT_W-1:0]  r_slot;
    logic               r_rep_pressed;
    logic [POS_W-1:0]   r_raw_x;
    logic [POS_W-1:0]   r_raw_y;
    logic [POS_W-1:0]   r_rx;
    logic [POS_W-1:0]   r_ry;
    logic               r_swap;

    // Output registers.
    logic [SLOT_W-1:0]     r_out_slot;
    logic                  r_out_pressed;
    logic [COORD_BITS-1:0] r_ui_x;
    logic [COORD_BITS-1:0] r_ui_y;

    logic                  found;
    logic                  any_free;
    logic [SLOT_W-1:0]     hit_slot;
    logic [SLOT_W-1:0]     free_slot;
    logic                  is_mouse;
    logic [PROD_W-1:0]     touch_x;
    logic [PROD_W-1:0]     touch_y;
    logic [DIM_W-1:0]      pw_nz;
    logic [DIM_W-1:0]      ph_nz;
    logic [POS_W-1:0]      flip_x;
    logic [POS_W-1:0]      flip_y;
    logic [PROD_W-1:0]     num_x;
    logic [PROD_W-1:0]     num_y;
    logic [DIM_W-1:0]      den_x;
    logic [DIM_W-1:0]      den_y;
    logic                  done_x;
    logic                  done_y;
    logic [PROD_W-1:0]     quo_x;
    logic [PROD_W-1:0]     quo_y;
    logic [COORD_BITS-1:0] hi_x;
    logic [COORD_BITS-1:0] hi_y;

    // Positive part of (dim - 1) - raw, zero when the difference is not positive.
    function automatic logic [POS_W-1:0] flip_pos(input logic [DIM_W-1:0] dim,
                                                  input logic [POS_W-1:0] raw);
        logic signed [DIFF_W-1:0] d;
        d = $signed({{(DIFF_W-DIM_W){1'b0}}, dim - 1'b1})
            - $signed({{(DIFF_W-POS_W){1'b0}}, raw});
        return (d > 0) ? d[POS_W-1:0] : '0;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_hi(input logic [DIM_W-1:0] ui);
        logic [DIM_W-1:0] m;
        m = ui - 1'b1;
        return (m > DIM_W'(COORD_MAX)) ? COORD_MAX : m[COORD_BITS-1:0];
    endfunction

    always_comb begin
        found     = 1'b0;
        any_free  = 1'b0;
        hit_slot  = '0;
        free_slot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_active[i] && (r_cid[i] == r_id) && !(i == 0 && r_mouse)) begin
                found    = 1'b1;
                hit_slot = SLOT_W'(i);
            end
            if (!r_active[i]) begin
                any_free  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        o_status.div_done = done_x;
        case (r_op)
            OP_FINGER_DOWN: o_status.report = 1'b1;
            OP_FINGER_UP:   o_status.report = found;
            OP_FINGER_MOVE: o_status.report = found;
            OP_MOUSE_DOWN:  o_status.report = r_left;
            OP_MOUSE_UP:    o_status.report = r_left;
            OP_MOUSE_MOVE:  o_status.report = r_pressed[0];
            default:        o_status.report = 1'b0;
        endcase
    end

    assign is_mouse = (r_op == OP_MOUSE_DOWN) || (r_op == OP_MOUSE_UP)
                      || (r_op == OP_MOUSE_MOVE);
    assign touch_x  = r_px * i_cfg.panel_width;
    assign touch_y  = r_py * i_cfg.panel_height;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_operation);
            r_id   <= i_finger_id;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_left <= i_left_button;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_active[i]  <= 1'b0;
                r_cid[i]     <= '0;
                r_pressed[i] <= 1'b0;
            end
            r_mouse <= 1'b0;
        end else if (i_cmd.look) begin
            case (r_op)
                OP_FINGER_DOWN: begin
                    if (found) begin
                        r_pressed[hit_slot] <= 1'b1;
                    end else if (any_free) begin
                        r_active[free_slot]  <= 1'b1;
                        r_cid[free_slot]     <= r_id;
                        r_pressed[free_slot] <= 1'b1;
                        if (free_slot == '0) begin
                            r_mouse <= 1'b0;
                        end
                    end else begin
                        r_pressed[0] <= 1'b1;
                    end
                end
                OP_FINGER_UP: begin
                    if (found) begin
                        r_pressed[hit_slot] <= 1'b0;
                        r_active[hit_slot]  <= 1'b0;
                        r_cid[hit_slot]     <= '0;
                    end
                end
                OP_MOUSE_DOWN: begin
                    if (r_left) begin
                        r_active[0]  <= 1'b1;
                        r_cid[0]     <= '0;
                        r_pressed[0] <= 1'b1;
                        r_mouse      <= 1'b1;
                    end
                end
                OP_MOUSE_UP: begin
                    if (r_left) begin
                        r_active[0]  <= 1'b0;
                        r_cid[0]     <= '0;
                        r_pressed[0] <= 1'b0;
                        r_mouse      <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Slot and pressed mark of the report, and the raw panel position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            case (r_op)
                OP_FINGER_DOWN: begin
                    r_slot        <= found ? hit_slot : (any_free ? free_slot : '0);
                    r_rep_pressed <= 1'b1;
                end
                OP_FINGER_UP: begin
                    r_slot        <= hit_slot;
                    r_rep_pressed <= 1'b0;
                end
                OP_FINGER_MOVE: begin
                    r_slot        <= hit_slot;
                    r_rep_pressed <= r_pressed[hit_slot];
                end
                OP_MOUSE_UP: begin
                    r_slot        <= '0;
                    r_rep_pressed <= 1'b0;
                end
                default: begin
                    r_slot        <= '0;
                    r_rep_pressed <= 1'b1;
                end
            endcase
            r_raw_x <= is_mouse ? r_px : POS_W'(touch_x[PROD_W-1:POS_W]);
            r_raw_y <= is_mouse ? r_py : POS_W'(touch_y[PROD_W-1:POS_W]);
        end
    end

    assign pw_nz  = (i_cfg.panel_width == '0) ? DIM_W'(1) : i_cfg.panel_width;
    assign ph_nz  = (i_cfg.panel_height == '0) ? DIM_W'(1) : i_cfg.panel_height;
    assign flip_x = flip_pos(pw_nz, r_raw_x);
    assign flip_y = flip_pos(ph_nz, r_raw_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rot) begin
            case (i_cfg.rotation)
                ROT_90: begin
                    r_rx <= r_raw_y;
                    r_ry <= flip_x;
                end
                ROT_180: begin
                    r_rx <= flip_x;
                    r_ry <= flip_y;
                end
                ROT_270: begin
                    r_rx <= flip_y;
                    r_ry <= r_raw_x;
                end
                default: begin
                    r_rx <= r_raw_x;
                    r_ry <= r_raw_y;
                end
            endcase
            r_swap <= i_cfg.rotation[0];
        end
    end

    assign num_x = r_rx * i_cfg.ui_width;
    assign num_y = r_ry * i_cfg.ui_height;
    assign den_x = r_swap ? ph_nz : pw_nz;
    assign den_y = r_swap ? pw_nz : ph_nz;

    tcst_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mul),
        .i_dividend (num_x),
        .i_divisor  (den_x),
        .o_done     (done_x),
        .o_quotient (quo_x)
    );

    tcst_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mul),
        .i_dividend (num_y),
        .i_divisor  (den_y),
        .o_done     (done_y),
        .o_quotient (quo_y)
    );

    assign hi_x = clamp_hi(i_cfg.ui_width);
    assign hi_y = clamp_hi(i_cfg.ui_height);

    // Both dividers start together and run the same length, so done_y mirrors done_x.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && done_y) begin
            r_out_slot    <= r_slot;
            r_out_pressed <= r_rep_pressed;
            r_ui_x <= (quo_x > PROD_W'(hi_x)) ? hi_x : quo_x[COORD_BITS-1:0];
            r_ui_y <= (quo_y > PROD_W'(hi_y)) ? hi_y : quo_y[COORD_BITS-1:0];
        end
    end

    assign o_slot_index = OUT_SLOT_W'(r_out_slot);
    assign o_is_pressed = r_out_pressed;
    assign o_ui_x       = r_ui_x;
    assign o_ui_y       = r_ui_y;

endmodule

// ===== rtl/core/tcst_ctrl.sv =====
// Sequencing state machine of the tracker.
module tcst_ctrl import tcst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_ROT,
        S_MUL,
        S_DIV
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_status.report ? S_ROT : S_IDLE;
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.emit = 1'b1;
                    n_valid    = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the touch contact slot tracker.
module tb_top;
    import tcst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Undefined operation codes. The tracker must ignore them.
    localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;

    // A reporting event is busy until its dividers finish; the settle wait
    // outlasts that, letting any event finish before a register write.
    localparam int SETTLE_CYCLES = 40;
    // Cycles with no transfer at all before the run is declared hung.
    localparam int STALL_LIMIT   = 3000;
    // Events per configuration phase of the random part.
    localparam int PHASE_EVENTS  = 209;
    localparam int ID_POOL_SIZE  = 12;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [ID_BITS-1:0] finger_id;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic               left_button;
    } t_event;

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] slot;
        logic                  pressed;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_report;

    // Clock, reset and every block input start at known values.
    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic                  busy;
    logic [OP_W-1:0]       i_operation   = '0;
    logic [ID_BITS-1:0]    i_finger_id   = '0;
    logic [POS_W-1:0]      i_pos_x       = '0;
    logic [POS_W-1:0]      i_pos_y       = '0;
    logic                  i_left_button = 1'b0;
    logic                  o_valid;
    logic [OUT_SLOT_W-1:0] o_slot_index;
    logic                  o_is_pressed;
    logic [COORD_BITS-1:0] o_ui_x;
    logic [COORD_BITS-1:0] o_ui_y;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    touch_contact_slot_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_finger_id   (i_finger_id),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_left_button (i_left_button),
        .o_valid       (o_valid),
        .o_slot_index  (o_slot_index),
        .o_is_pressed  (o_is_pressed),
        .o_ui_x        (o_ui_x),
        .o_ui_y        (o_ui_y),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow of the configuration registers, updated as each write lands.
    logic [1:0]       cfg_rotation = ROT_RESET;
    logic [DIM_W-1:0] cfg_panel_w  = PANEL_W_RST;
    logic [DIM_W-1:0] cfg_panel_h  = PANEL_H_RST;
    logic [DIM_W-1:0] cfg_ui_w     = UI_W_RST;
    logic [DIM_W-1:0] cfg_ui_h     = UI_H_RST;

    // Shadow of the contact table. All of it clears at reset.
    logic               slot_active  [SLOT_COUNT] = '{default: 1'b0};
    logic [ID_BITS-1:0] slot_id      [SLOT_COUNT] = '{default: '0};
    logic               slot_pressed [SLOT_COUNT] = '{default: 1'b0};
    logic               mouse_holds_slot0 = 1'b0;

    // Events waiting for the driver, the event now offered on the ports, and
    // the reports that accepted events still owe, oldest first.
    t_event  pending_events [$];
    t_event  offered_event;
    t_report expected_reports [$];
    t_report oldest_report;

    logic [ID_BITS-1:0] id_pool [ID_POOL_SIZE];
    int unsigned send_idle_pct     = 28;
    int unsigned failures          = 0;
    int unsigned stall_cycles      = 0;
    logic        last_accept       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction of the tracker.
    // ------------------------------------------------------------------

    // Slot that a finger already holds, or -1. While the mouse owns slot 0
    // no finger can match it, even one whose id happens to be zero.
    function automatic int find_contact(input logic [ID_BITS-1:0] id);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (i == 0 && mouse_holds_slot0)
                continue;
            if (slot_active[i] && slot_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    // Slot for a finger-down: the finger's own slot, else the first free one,
    // else slot 0. In that last case the table is left as it was.
    function automatic int claim_contact(input logic [ID_BITS-1:0] id);
        int s;
        s = find_contact(id);
        if (s >= 0)
            return s;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!slot_active[i]) begin
                slot_active[i] = 1'b1;
                slot_id[i]     = id;
                if (i == 0)
                    mouse_holds_slot0 = 1'b0;
                return i;
            end
        end
        return 0;
    endfunction

    // One axis: floor division of position times UI size by the panel size,
    // clamped to one below the UI size and to the coordinate width.
    // Negative positions and a zero UI size give 0.
    function automatic logic [COORD_BITS-1:0] scale_axis(input longint pos,
                                                         input longint ui_dim,
                                                         input longint panel_dim);
        longint v;
        longint hi;
        if (pos <= 0 || ui_dim == 0)
            return '0;
        v  = (pos * ui_dim) / panel_dim;
        hi = ui_dim - 1;
        if (hi > longint'(COORD_MAX))
            hi = longint'(COORD_MAX);
        if (v > hi)
            v = hi;
        return COORD_BITS'(v);
    endfunction

    // Rotates the raw panel position and maps it to UI coordinates. A panel
    // size of zero counts as one in every division.
    function automatic t_report ui_report(input int slot, input logic pressed,
                                          input longint raw_x, input longint raw_y);
        t_report r;
        longint  pw, ph, rx, ry, dx, dy;
        pw = (cfg_panel_w == '0) ? 1 : longint'(cfg_panel_w);
        ph = (cfg_panel_h == '0) ? 1 : longint'(cfg_panel_h);
        case (cfg_rotation)
            ROT_90: begin
                rx = raw_y;            ry = (pw - 1) - raw_x; dx = ph; dy = pw;
            end
            ROT_180: begin
                rx = (pw - 1) - raw_x; ry = (ph - 1) - raw_y; dx = pw; dy = ph;
            end
            ROT_270: begin
                rx = (ph - 1) - raw_y; ry = raw_x;            dx = ph; dy = pw;
            end
            default: begin
                rx = raw_x;            ry = raw_y;            dx = pw; dy = ph;
            end
        endcase
        r.slot    = OUT_SLOT_W'(slot);
        r.pressed = pressed;
        r.x       = scale_axis(rx, longint'(cfg_ui_w), dx);
        r.y       = scale_axis(ry, longint'(cfg_ui_h), dy);
        return r;
    endfunction

    task automatic owe_report(input t_report r);
        expected_reports.push_back(r);
    endtask

    // Applies one accepted event to the shadow table and queues its report.
    task automatic predict_event(input t_event ev);
        longint tx, ty, mx, my;
        int     s;
        // Touch positions are fractions of the panel; mouse positions are pixels.
        tx = (longint'(ev.pos_x) * longint'(cfg_panel_w)) >>> 16;
        ty = (longint'(ev.pos_y) * longint'(cfg_panel_h)) >>> 16;
        mx = longint'(ev.pos_x);
        my = longint'(ev.pos_y);
        case (ev.operation)
            OP_FINGER_DOWN: begin
                s = claim_contact(ev.finger_id);
                slot_pressed[s] = 1'b1;
                owe_report(ui_report(s, 1'b1, tx, ty));
            end
            OP_FINGER_UP: begin
                s = find_contact(ev.finger_id);
                if (s >= 0) begin
                    slot_pressed[s] = 1'b0;
                    owe_report(ui_report(s, 1'b0, tx, ty));
                    slot_active[s] = 1'b0;
                    slot_id[s]     = '0;
                end
            end
            OP_FINGER_MOVE: begin
                s = find_contact(ev.finger_id);
                if (s >= 0)
                    owe_report(ui_report(s, slot_pressed[s], tx, ty));
            end
            OP_MOUSE_DOWN: begin
                if (ev.left_button) begin
                    slot_active[0]    = 1'b1;
                    slot_id[0]        = '0;
                    slot_pressed[0]   = 1'b1;
                    mouse_holds_slot0 = 1'b1;
                    owe_report(ui_report(0, 1'b1, mx, my));
                end
            end
            OP_MOUSE_UP: begin
                // Releases slot 0 whoever holds it.
                if (ev.left_button) begin
                    slot_pressed[0] = 1'b0;
                    owe_report(ui_report(0, 1'b0, mx, my));
                    slot_active[0]    = 1'b0;
                    slot_id[0]        = '0;
                    mouse_holds_slot0 = 1'b0;
                end
            end
            OP_MOUSE_MOVE: begin
                if (slot_pressed[0])
                    owe_report(ui_report(0, 1'b1, mx, my));
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------

    // Full-range values and small pixel-sized values in equal share, with the
    // extremes mixed in, so mouse positions land both on and off the panel.
    function automatic logic [POS_W-1:0] random_pos();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else if (pick < 6)
            return POS_W'($urandom_range(0, 4200));
        else
            return POS_W'($urandom());
    endfunction

    // Well-formed traffic uses a small pool of finger ids, so contacts come
    // back down, move and lift, and the table often runs full. A few percent
    // is noise: any operation code with any id and button.
    function automatic t_event random_event();
        t_event      ev;
        int unsigned pick;
        pick           = $urandom_range(0, 99);
        ev.finger_id   = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        ev.pos_x       = random_pos();
        ev.pos_y       = random_pos();
        ev.left_button = ($urandom_range(0, 99) < 88);
        if (pick < 30)
            ev.operation = OP_FINGER_DOWN;
        else if (pick < 50)
            ev.operation = OP_FINGER_MOVE;
        else if (pick < 70)
            ev.operation = OP_FINGER_UP;
        else if (pick < 78)
            ev.operation = OP_MOUSE_DOWN;
        else if (pick < 87)
            ev.operation = OP_MOUSE_MOVE;
        else if (pick < 94)
            ev.operation = OP_MOUSE_UP;
        else begin
            ev.operation   = OP_W'($urandom_range(0, 7));
            ev.finger_id   = ID_BITS'($urandom());
            ev.left_button = 1'($urandom_range(0, 1));
        end
        return ev;
    endfunction

    task automatic queue_event(input logic [OP_W-1:0] op, input logic [ID_BITS-1:0] id,
                               input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                               input logic left);
        pending_events.push_back(t_event'{op, id, x, y, left});
    endtask

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------

    // Writes one register, then reads it straight back. Between the two
    // transfers psel simply stays high, so it is never lowered and raised
    // within one time step.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
        logic [APB_DATA_W-1:0] stored;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_ROTATION:     cfg_rotation = value[1:0];
            REG_PANEL_WIDTH:  cfg_panel_w  = value[DIM_W-1:0];
            REG_PANEL_HEIGHT: cfg_panel_h  = value[DIM_W-1:0];
            REG_UI_WIDTH:     cfg_ui_w     = value[DIM_W-1:0];
            default:          cfg_ui_h     = value[DIM_W-1:0];
        endcase
        stored = (idx == REG_ROTATION) ? APB_DATA_W'(value[1:0])
                                       : APB_DATA_W'(value[DIM_W-1:0]);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== stored) begin
            $display("%0t ns: register %0d readback mismatch, expected %0d, actual %0d",
                     $time, idx, stored, prdata);
            failures++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Phase control.
    // ------------------------------------------------------------------

    // Waits until every queued event has been taken and every report owed
    // has arrived, then lets the tracker settle. An event that ends without a
    // report may still be finishing when the last report shows up.
    task automatic wait_idle();
        while (pending_events.size() != 0 || start || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One configuration phase of the random part: program every register,
    // feed the driver until the phase's events have been queued, then wait idle.
    task automatic run_phase(input logic [1:0] rot, input int unsigned pw,
                             input int unsigned ph, input int unsigned uw,
                             input int unsigned uh, input int unsigned idle_pct);
        int unsigned sent;
        write_reg(REG_ROTATION,     32'(rot));
        write_reg(REG_PANEL_WIDTH,  pw);
        write_reg(REG_PANEL_HEIGHT, ph);
        write_reg(REG_UI_WIDTH,     uw);
        write_reg(REG_UI_HEIGHT,    uh);
        send_idle_pct = idle_pct;
        sent = 0;
        while (sent < PHASE_EVENTS) begin
            if (pending_events.size() < 4) begin
                pending_events.push_back(random_event());
                sent++;
            end else begin
                @(posedge i_clk);
            end
        end
        wait_idle();
    endtask

    initial begin
        // Ids 0 and all-ones are in the pool so every id bit takes both values
        // in ordinary traffic; finger id 0 also collides with the mouse slot.
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int k = 2; k < ID_POOL_SIZE; k++)
            id_pool[k] = ID_BITS'($urandom());

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset configuration. Two fingers go down at the
        // position extremes and one of them moves, unknown fingers move and
        // lift, eight more fingers fill the table, a new finger finds it full
        // and falls back to slot 0, and the second finger lifts.
        queue_event(OP_FINGER_DOWN, id_pool[0], '0, '0, 1'b0);
        queue_event(OP_FINGER_DOWN, id_pool[1], '1, '1, 1'b1);
        queue_event(OP_FINGER_MOVE, id_pool[1], 16'h8000, 16'h8000, 1'b0);
        queue_event(OP_FINGER_MOVE, 16'h1234, 16'h4000, 16'hC000, 1'b0);
        queue_event(OP_FINGER_UP,   16'h5555, 16'h1000, 16'h2000, 1'b1);
        for (int k = 2; k < 10; k++)
            queue_event(OP_FINGER_DOWN, id_pool[k], random_pos(), random_pos(), 1'b0);
        queue_event(OP_FINGER_DOWN, id_pool[10], 16'h7FFF, 16'h0001, 1'b0);
        queue_event(OP_FINGER_UP,   id_pool[1], 16'hFFFF, 16'h0000, 1'b0);
        // Mouse traffic: a right-button press is ignored, a left press takes
        // slot 0 away from its finger, which then no longer matches. Motion
        // far off the panel must clamp; after release motion is ignored.
        queue_event(OP_MOUSE_DOWN,  16'hFFFF, 16'd10, 16'd10, 1'b0);
        queue_event(OP_MOUSE_DOWN,  16'h0000, 16'd640, 16'd400, 1'b1);
        queue_event(OP_FINGER_MOVE, id_pool[0], 16'h2000, 16'h2000, 1'b0);
        queue_event(OP_MOUSE_MOVE,  16'h0000, '1, '1, 1'b0);
        queue_event(OP_MOUSE_UP,    16'h0000, 16'd5, 16'd5, 1'b0);
        queue_event(OP_MOUSE_UP,    16'h0000, '0, '0, 1'b1);
        queue_event(OP_MOUSE_MOVE,  16'h0000, 16'd100, 16'd100, 1'b1);
        // Undefined operations with every other field at all-ones.
        queue_event(OP_RESERVED_A, '1, '1, '1, 1'b1);
        queue_event(OP_RESERVED_B, '1, '1, '1, 1'b1);
        queue_event(OP_FINGER_DOWN, id_pool[10], 16'h0100, 16'hFF00, 1'b0);
        wait_idle();

        // Random part. The first three phases have the sender idle in about
        // a quarter of its cycles, the next three in about three quarters,
        // the last three never. Each phase covers a different rotation and
        // size setting, including sizes of 4096, sizes of one, and zero
        // panel and UI sizes.
        run_phase(ROT_90,  1280, 800, 1280, 800, 28);
        run_phase(ROT_180, 4096, 4096, 4096, 4096, 28);
        run_phase(ROT_270, 1, 1, 1, 1, 28);
        run_phase(ROT_0, $urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(1, 4096), $urandom_range(1, 4096), 74);
        run_phase(ROT_90, 0, 4096, 4096, 0, 74);
        run_phase(ROT_180, $urandom_range(1, 4096), 0, 0, $urandom_range(1, 4096), 74);
        run_phase(ROT_270, 4096, 1, 1, 4096, 0);
        run_phase(2'($urandom_range(0, 3)), $urandom_range(1, 4096),
                  $urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(1, 4096), 0);
        run_phase(ROT_RESET, 32'(PANEL_W_RST), 32'(PANEL_H_RST), 32'(UI_W_RST),
                  32'(UI_H_RST), 0);

        if (expected_reports.size() != 0) begin
            $display("%0t ns: %0d expected reports never arrived",
                     $time, expected_reports.size());
            failures++;
        end
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. An offered event stays on
    // the ports until a rising edge sees start high with busy low. When it
    // is taken, the next event may follow at once, so start stays high
    // without a gap, or the sender may idle at random.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && !(start && !last_accept)) begin
            if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                offered_event = pending_events.pop_front();
                start         <= 1'b1;
                i_operation   <= offered_event.operation;
                i_finger_id   <= offered_event.finger_id;
                i_pos_x       <= offered_event.pos_x;
                i_pos_y       <= offered_event.pos_y;
                i_left_button <= offered_event.left_button;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples on the rising edge. A report, marked by o_valid for
    // one cycle only, is compared with the oldest report owed. An event taken
    // at the same edge is predicted afterwards; its report can only come
    // much later, so the order between the two does not matter.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            last_accept <= 1'b0;
        end else begin
            if (o_valid === 1'b1) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: unexpected report, slot %0d pressed %0d x %0d y %0d",
                             $time, o_slot_index, o_is_pressed, o_ui_x, o_ui_y);
                    failures++;
                end else begin
                    oldest_report = expected_reports.pop_front();
                    check_field("slot_index", 16'(oldest_report.slot), 16'(o_slot_index));
                    check_field("is_pressed", 16'(oldest_report.pressed), 16'(o_is_pressed));
                    check_field("ui_x", 16'(oldest_report.x), 16'(o_ui_x));
                    check_field("ui_y", 16'(oldest_report.y), 16'(o_ui_y));
                end
            end
            if (start && busy === 1'b0)
                predict_event(offered_event);
            last_accept <= start && busy === 1'b0;
        end
    end

    // Watchdog: any event transfer, report or register transfer restarts the
    // count of quiet cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1
            || (psel && penable)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// ===== filelist.f =====
rtl/core/tcst_pkg.sv
rtl/core/tcst_regs.sv
rtl/core/tcst_div.sv
rtl/core/tcst_datapath.sv
rtl/core/tcst_ctrl.sv
rtl/core/touch_contact_slot_tracker.sv
bench/tb_top.sv
